[design/cnrs_pkg.sv]
// shared types, register codes and saturation helpers for the cubic newton solver
`default_nettype none

package cnrs_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_CUBIC = 3'd0,
    REG_COEF_LINEAR = 3'd1,
    REG_TOL_RESIDUAL = 3'd2,
    REG_TOL_STEP = 3'd3,
    REG_SLOPE_FLOOR = 3'd4,
    REG_USE_FLOOR = 3'd5,
    REG_ITER_LIMIT = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STAT_CONV = 2'd0,
    STAT_LIMIT = 2'd1,
    STAT_ZERO = 2'd2
  } status_e;

  localparam logic signed [63:0] SatHi = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] SatLo = -64'sh0000_0000_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SatHi) begin
      r = 32'sh7fff_ffff;
    end else if (v < SatLo) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // magnitude of a signed word, the most negative value maps to 2^31
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

[design/cnrs_mul.sv]
// shared signed 32x32 multiplier with registered product
`default_nettype none

module cnrs_mul import cnrs_pkg::*; (
  input  wire                      clk_i,
  input  wire logic signed [31:0]  a_i,
  input  wire logic signed [31:0]  b_i,
  output logic signed [63:0]       p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[design/cnrs_div.sv]
// radix-2 restoring divider for the newton step, (num * 2^frac) / den with saturation
`default_nettype none

module cnrs_div import cnrs_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire logic signed [31:0]  num_i,
  input  wire logic signed [31:0]  den_i,
  output logic                     done_o,
  output logic signed [31:0]       quot_o
);

  localparam int unsigned NumW = 32 + FRAC_BITS;
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam logic [NumW-1:0] MagMin = NumW'(64'h0000_0000_8000_0000);
  localparam logic [NumW-1:0] MagMax = NumW'(64'h0000_0000_7fff_ffff);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic            neg_q;
  logic [NumW-1:0] acc_q;
  logic [31:0]     rem_q;
  logic [31:0]     den_q;
  logic            done_q;
  logic signed [31:0] quot_q;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_q, acc_q[NumW-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      acc_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      done_q <= 1'b0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
        neg_q  <= num_i[31] ^ den_i[31];
        acc_q  <= {abs32(num_i), {FRAC_BITS{1'b0}}};
        den_q  <= abs32(den_i);
        rem_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          // quotient bits shift in where dividend bits leave
          rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
          acc_q <= {acc_q[NumW-2:0], ge};
          cnt_q <= cnt_q - CntW'(1);
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          if (neg_q) begin
            quot_q <= (acc_q > MagMin) ? 32'sh8000_0000 : (~acc_q[31:0] + 32'd1);
          end else begin
            quot_q <= (acc_q > MagMax) ? 32'sh7fff_ffff : acc_q[31:0];
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("divider done longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_q) && $past(cnt_q) == '0))
    else $error("divider done without a finished run");

endmodule

`default_nettype wire

[design/cubic_newton_root_solver.sv]
// top level of the cubic newton root solver: sequencer, config registers, result word
// solves A3*x^3 - 9*A2*x + 3 = 0 by newton steps in signed fixed point (FRAC_BITS fraction)
// usage:
//   write the config registers through cfg_we_i / cfg_idx_i / cfg_wdata_i while busy is low
//   pulse start with start_x_i; the word is taken when start is high and busy is low
//   busy stays high until the result word is out; then done_o is high for one cycle
//   with root_x_o, residual_o, steps_taken_o and status_o (held until the next result)
// sequence:
//   the start point is checked first; if it already meets the residual
//   tolerance the result follows at once
//   each newton step runs six states on the one shared multiplier (five products, the
//   last one landing in the sixth state), one decision state, the bit-serial divider
//   (32 + FRAC_BITS iterations) and two update states
//   a zero slope ends the run at the decision state, before the divider is started
// throughput: one item at a time; a new start is taken in the cycle done_o is high
// reset clears the config registers to their defaults and the sequencer to idle
// the receiver cannot stall: each result word is flagged by done_o for one cycle only
`default_nettype none

module cubic_newton_root_solver import cnrs_pkg::*; #(
  parameter int unsigned MAX_STEPS = 255,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire logic signed [31:0]      start_x_i,
  input  wire                          cfg_we_i,
  input  wire logic [CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [CfgDataW-1:0]     cfg_wdata_i,
  output logic                         done_o,
  output logic signed [31:0]           root_x_o,
  output logic signed [31:0]           residual_o,
  output logic [7:0]                   steps_taken_o,
  output logic [1:0]                   status_o
);

  localparam logic [7:0] MaxSteps = 8'(MAX_STEPS);
  localparam logic signed [63:0] ThreeFx = 64'sd3 <<< FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_EVAL,
    ST_DIV,
    ST_UPD,
    ST_CHK
  } state_e;

  // config registers
  logic signed [31:0] coef_cubic_q, coef_linear_q;
  logic [30:0]        tol_res_q, tol_step_q, floor_q;
  logic               use_floor_q;
  logic [7:0]         iter_lim_q;

  // datapath registers
  state_e             state_q;
  logic signed [31:0] x_q, sq_q, cu_q, t2_q, t1s_q, f_q, d_q, held_q, nx_q;
  logic [7:0]         cnt_q;
  logic               first_q;

  // result word
  logic               done_q;
  logic signed [31:0] root_q, res_q;
  logic [7:0]         steps_q;
  status_e            status_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p, p_scaled;
  logic signed [31:0] p_sat;
  logic signed [31:0] div_q;
  logic               div_done, div_start;

  logic [7:0]         lim_cap, lim;
  logic               f_small, d_big, d_keep, step_small;
  logic signed [31:0] d_use;
  logic [32:0]        step_diff, step_abs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_cubic_q  <= 32'sd65536;
      coef_linear_q <= 32'sd65536;
      tol_res_q     <= 31'd3277;
      tol_step_q    <= 31'd3277;
      floor_q       <= 31'd3277;
      use_floor_q   <= 1'b0;
      iter_lim_q    <= 8'd64;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_COEF_CUBIC:   coef_cubic_q  <= cfg_wdata_i;
        REG_COEF_LINEAR:  coef_linear_q <= cfg_wdata_i;
        REG_TOL_RESIDUAL: tol_res_q     <= cfg_wdata_i[30:0];
        REG_TOL_STEP:     tol_step_q    <= cfg_wdata_i[30:0];
        REG_SLOPE_FLOOR:  floor_q       <= cfg_wdata_i[30:0];
        REG_USE_FLOOR:    use_floor_q   <= cfg_wdata_i[0];
        REG_ITER_LIMIT:   iter_lim_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // operand schedule, each product lands in the following state
  always_comb begin
    case (state_q)
      ST_M1: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      ST_M2: begin
        mul_a = coef_linear_q;
        mul_b = x_q;
      end
      ST_M3: begin
        mul_a = sq_q;
        mul_b = x_q;
      end
      ST_M4: begin
        mul_a = coef_cubic_q;
        mul_b = sq_q;
      end
      ST_M5: begin
        mul_a = coef_cubic_q;
        mul_b = cu_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = x_q;
      end
    endcase
  end

  cnrs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // floor rounding is an arithmetic shift
  assign p_scaled = mul_p >>> FRAC_BITS;
  assign p_sat    = sat32(p_scaled);

  always_comb begin
    lim_cap    = (iter_lim_q > MaxSteps) ? MaxSteps : iter_lim_q;
    lim        = (lim_cap == 8'd0) ? 8'd1 : lim_cap;
    f_small    = abs32(f_q) < {1'b0, tol_res_q};
    d_big      = abs32(d_q) > {1'b0, floor_q};
    // first step and plain mode always take the fresh slope
    d_keep     = first_q || !use_floor_q || d_big;
    d_use      = d_keep ? d_q : held_q;
    div_start  = (state_q == ST_EVAL) && !(first_q && f_small) && (d_use != 32'sd0);
    step_diff  = {nx_q[31], nx_q} - {x_q[31], x_q};
    step_abs   = step_diff[32] ? (~step_diff + 33'd1) : step_diff;
    step_small = step_abs < {2'b00, tol_step_q};
  end

  cnrs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (f_q),
    .den_i   (d_use),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      x_q      <= '0;
      sq_q     <= '0;
      cu_q     <= '0;
      t2_q     <= '0;
      t1s_q    <= '0;
      f_q      <= '0;
      d_q      <= '0;
      held_q   <= '0;
      nx_q     <= '0;
      cnt_q    <= '0;
      first_q  <= 1'b0;
      done_q   <= 1'b0;
      root_q   <= '0;
      res_q    <= '0;
      steps_q  <= '0;
      status_q <= STAT_CONV;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            x_q     <= start_x_i;
            cnt_q   <= '0;
            first_q <= 1'b1;
            state_q <= ST_M1;
          end
        end
        ST_M1: state_q <= ST_M2;
        ST_M2: begin
          sq_q    <= p_sat;
          state_q <= ST_M3;
        end
        ST_M3: begin
          t2_q    <= sat32((p_scaled <<< 3) + p_scaled);
          state_q <= ST_M4;
        end
        ST_M4: begin
          cu_q    <= p_sat;
          state_q <= ST_M5;
        end
        ST_M5: begin
          t1s_q   <= sat32((sx32(p_sat) <<< 1) + sx32(p_sat));
          state_q <= ST_M6;
        end
        ST_M6: begin
          f_q     <= sat32(sx32(p_sat) - sx32(t2_q) + ThreeFx);
          d_q     <= sat32(sx32(t1s_q) - ((sx32(coef_linear_q) <<< 3) + sx32(coef_linear_q)));
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (d_keep) begin
            held_q <= d_q;
          end
          if (first_q && f_small) begin
            root_q   <= x_q;
            res_q    <= f_q;
            steps_q  <= '0;
            status_q <= STAT_CONV;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else if (d_use == 32'sd0) begin
            root_q   <= x_q;
            res_q    <= f_q;
            steps_q  <= cnt_q;
            status_q <= STAT_ZERO;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          nx_q    <= sat32(sx32(x_q) - sx32(div_q));
          cnt_q   <= cnt_q + 8'd1;
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (f_small || step_small) begin
            root_q   <= nx_q;
            res_q    <= f_q;
            steps_q  <= cnt_q;
            status_q <= STAT_CONV;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            x_q     <= nx_q;
            first_q <= 1'b0;
            if (cnt_q >= lim) begin
              root_q   <= nx_q;
              res_q    <= f_q;
              steps_q  <= cnt_q;
              status_q <= STAT_LIMIT;
              done_q   <= 1'b1;
              state_q  <= ST_IDLE;
            end else begin
              state_q <= ST_M1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign root_x_o      = root_q;
  assign residual_o    = res_q;
  assign steps_taken_o = steps_q;
  assign status_o      = status_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word while still busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted word did not start a run");

  a_limit_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_LIMIT) |-> (steps_taken_o == lim))
    else $error("limit status with wrong step count");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (steps_taken_o <= lim))
    else $error("more steps than the limit");

endmodule

`default_nettype wire

[sim/tb.sv]
// self-checking testbench for the cubic newton root solver, directed then random configs
`timescale 1ns / 1ps

module tb;
  import cnrs_pkg::*;

  localparam int FracBits = 16;
  localparam int StepCap = 255;
  localparam int WdLimit = 60000;
  localparam longint One = longint'(1) << FracBits;

  typedef struct {
    logic signed [31:0] root;
    logic signed [31:0] resid;
    logic [7:0]         steps;
    status_e            stat;
  } solve_word_t;

  class root_scoreboard;
    longint       a3, a2, tol_res, tol_stp, lambda;
    bit           floor_on;
    int unsigned  limit_reg;
    longint       work_x, held_slope;
    int unsigned  step_cnt;
    solve_word_t  pending_q[$];
    int unsigned  errors;

    function new();
      a3 = 65536;
      a2 = 65536;
      tol_res = 3277;
      tol_stp = 3277;
      lambda = 3277;
      floor_on = 1'b0;
      limit_reg = 64;
      work_x = 0;
      held_slope = 0;
      step_cnt = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] v);
      case (idx)
        REG_COEF_CUBIC:   a3 = $signed(v);
        REG_COEF_LINEAR:  a2 = $signed(v);
        REG_TOL_RESIDUAL: tol_res = longint'(v[30:0]);
        REG_TOL_STEP:     tol_stp = longint'(v[30:0]);
        REG_SLOPE_FLOOR:  lambda = longint'(v[30:0]);
        REG_USE_FLOOR:    floor_on = v[0];
        REG_ITER_LIMIT:   limit_reg = v[7:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // exact product, floor to the fraction width, then clamp
    function longint fmul(longint a, longint b);
      return clamp32((a * b) >>> FracBits);
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint cubic_at(longint x);
      longint sq, cu, t1, t2;
      sq = fmul(x, x);
      cu = fmul(sq, x);
      t1 = fmul(a3, cu);
      t2 = clamp32(9 * ((a2 * x) >>> FracBits));
      return clamp32(t1 - t2 + 3 * One);
    endfunction

    function longint slope_at(longint x);
      longint sq, t1;
      sq = fmul(x, x);
      t1 = clamp32(3 * fmul(a3, sq));
      return clamp32(t1 - 9 * a2);
    endfunction

    function void note_start(logic signed [31:0] x0);
      longint      f, d, nx;
      int unsigned lim;
      status_e     st;
      solve_word_t w;
      lim = (limit_reg > StepCap) ? StepCap : limit_reg;
      if (lim == 0) lim = 1;
      work_x = x0;
      step_cnt = 0;
      f = cubic_at(work_x);
      nx = work_x;
      st = STAT_CONV;
      if (mag(f) >= tol_res) begin
        held_slope = slope_at(work_x);
        forever begin
          f = cubic_at(work_x);
          d = slope_at(work_x);
          if (floor_on) begin
            if (mag(d) > lambda) held_slope = d;
            else d = held_slope;
          end else begin
            held_slope = d;
          end
          if (d == 0) begin
            nx = work_x;
            st = STAT_ZERO;
            break;
          end
          nx = clamp32(work_x - clamp32((f * One) / d));
          step_cnt = (step_cnt + 1) & 8'hff;
          if (mag(f) < tol_res || mag(nx - work_x) < tol_stp) begin
            st = STAT_CONV;
            break;
          end
          work_x = nx;
          if (step_cnt >= lim) begin
            st = STAT_LIMIT;
            break;
          end
        end
      end
      w.root = nx[31:0];
      w.resid = f[31:0];
      w.steps = 8'(step_cnt);
      w.stat = st;
      pending_q.push_back(w);
    endfunction

    function void check_result(logic signed [31:0] root, logic signed [31:0] resid,
                               logic [7:0] steps, logic [1:0] stat);
      solve_word_t want;
      if (pending_q.size() == 0) begin
        $error("solver word with no start pending");
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (root !== want.root) begin
        $error("root_x: expected %0d, actual %0d", want.root, root);
        errors++;
      end
      if (resid !== want.resid) begin
        $error("residual: expected %0d, actual %0d", want.resid, resid);
        errors++;
      end
      if (steps !== want.steps) begin
        $error("steps_taken: expected %0d, actual %0d", want.steps, steps);
        errors++;
      end
      if (stat !== want.stat) begin
        $error("status: expected %0d, actual %0d", want.stat, stat);
        errors++;
      end
    endfunction

    function bit drained();
      return pending_q.size() == 0;
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [31:0]        start_x_i;
  logic               cfg_we_i;
  cfg_reg_e           cfg_idx_i;
  logic [31:0]        cfg_wdata_i;
  logic               done_o;
  logic signed [31:0] root_x_o;
  logic signed [31:0] residual_o;
  logic [7:0]         steps_taken_o;
  logic [1:0]         status_o;

  root_scoreboard sb;
  int idle_pct;

  cubic_newton_root_solver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .start_x_i     (start_x_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .root_x_o      (root_x_o),
    .residual_o    (residual_o),
    .steps_taken_o (steps_taken_o),
    .status_o      (status_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result check first, so a start taken in the done cycle queues behind it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(root_x_o, residual_o, steps_taken_o, status_o);
      if (start && !busy) sb.note_start(start_x_i);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WdLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    sb.set_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_solver(logic [31:0] a3, logic [31:0] a2, logic [31:0] tr,
                                logic [31:0] ts, logic [31:0] sf, logic [31:0] uf,
                                logic [31:0] lim);
    write_reg(REG_COEF_CUBIC, a3);
    write_reg(REG_COEF_LINEAR, a2);
    write_reg(REG_TOL_RESIDUAL, tr);
    write_reg(REG_TOL_STEP, ts);
    write_reg(REG_SLOPE_FLOOR, sf);
    write_reg(REG_USE_FLOOR, uf);
    write_reg(REG_ITER_LIMIT, lim);
  endtask

  // start stays high into the next word unless a gap is drawn
  task automatic send_item(logic [31:0] x);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      start_x_i <= $urandom();
      repeat ($urandom_range(1, 80)) @(posedge clk_i);
    end
    start <= 1'b1;
    start_x_i <= x;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (!sb.drained() || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_tol();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom();
      default: return $urandom_range(16, 32'h0000_8000);
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] x;
    logic [31:0] lim;
    int          items;
    sb = new();
    idle_pct = 0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    start_x_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_COEF_CUBIC;
    cfg_wdata_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // defaults after reset give f = x^3 - 9x + 3
    send_item(32'h0000_0000);
    send_item(32'd22125);  // about 0.3376, already close enough to a root
    send_item(32'h7fff_ffff);
    send_item(32'h8000_0000);
    send_item(32'hffff_ffff);
    send_item(32'h0000_0001);
    send_item(32'hfffc_0000);
    settle();

    // slope vanishes at x = +-3 once A2 is 3
    program_solver(32'h0001_0000, 32'h0003_0000, 3277, 3277, 3277, 0, 64);
    send_item(32'h0003_0000);
    send_item(32'hfffd_0000);
    settle();

    // flat line, no slope anywhere
    program_solver(32'h0, 32'h0, 3277, 3277, 3277, 0, 64);
    send_item($urandom());
    settle();

    // zero tolerances never converge: zero limit behaves as one, then 1, then the maximum
    program_solver(32'h0001_0000, 32'h0001_0000, 0, 0, 3277, 0, 0);
    send_item(32'h0005_0000);
    settle();
    write_reg(REG_ITER_LIMIT, 1);
    send_item(32'h0005_0000);
    settle();
    write_reg(REG_ITER_LIMIT, 255);
    send_item(32'h0002_0000);
    settle();

    program_solver(32'h0001_0000, 32'h0001_0000, 32'hffff_ffff, 32'hffff_ffff, 3277, 0, 64);
    send_item(32'h0001_0000);
    send_item(32'h7fff_ffff);
    settle();

    // floor mode with a huge lambda keeps the first slope throughout
    program_solver(32'h0001_0000, 32'h0001_0000, 3277, 3277, 32'h7fff_ffff, 1, 32);
    send_item(32'h0004_0000);
    send_item(32'hffff_0000);
    settle();

    // floor mode around the flat spot near sqrt(3)
    program_solver(32'h0001_0000, 32'h0001_0000, 3277, 3277, 32'h0005_0000, 1, 32);
    send_item(32'd113512);
    send_item(32'h0000_0000);
    settle();
    write_reg(REG_SLOPE_FLOOR, 0);
    send_item(32'd113512);
    settle();

    // coefficient extremes drive products into saturation
    program_solver(32'h7fff_ffff, 32'h8000_0000, 3277, 3277, 3277, 0, 8);
    send_item(32'h7fff_ffff);
    send_item(32'h8000_0000);
    send_item(32'h0001_0000);
    settle();
    program_solver(32'h8000_0000, 32'h7fff_ffff, 3277, 3277, 3277, 1, 8);
    send_item(32'h0001_0000);

    for (int ph = 0; ph < 14; ph++) begin
      settle();
      idle_pct = (ph < 4) ? 33 : (ph < 8) ? 66 : 0;
      if (ph == 13) begin
        // the largest limit, kept to well-behaved starts so the run stays short
        program_solver(32'h0001_0000, 32'h0001_0000, rand_tol() & 32'h0000_ffff,
                       rand_tol() & 32'h0000_ffff, rand_tol(), $urandom_range(0, 1), 255);
        items = 20;
      end else begin
        case ($urandom_range(0, 7))
          0: lim = 32'd0;
          1: lim = 32'd1;
          default: lim = $urandom_range(2, 12);
        endcase
        program_solver(rand_coef(), rand_coef(), rand_tol(), rand_tol(), rand_tol(),
                       $urandom_range(0, 1), lim);
        items = 100;
      end
      for (int n = 0; n < items; n++) begin
        case ($urandom_range(0, 9))
          0: x = $urandom();
          1: x = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
          default: x = $urandom_range(0, 32'h000c_0000) - 32'h0006_0000;
        endcase
        if (ph == 13) x = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        send_item(x);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
